>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Same check on the usual clock and reset names.
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

>>> src/wlnr_pkg.sv
// ----------------------------------------------------------------------------
// wlnr_pkg
// Widths, control word layout and status flags shared by the sequencer and
// the datapath of the windowed longest non-decreasing run search.
// ----------------------------------------------------------------------------
package wlnr_pkg;

    localparam int MAX_ITEMS_DEF = 512;

    localparam int VALUE_W  = 32;
    localparam int WLEN_W   = 10;
    localparam int BLEN_W   = 11;
    localparam int WSTART_W = 10;
    localparam int WEND_W   = 11;
    localparam int OTDATA_W = BLEN_W + WSTART_W + WEND_W;

    localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(1);

    localparam int PC_W = 5;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_NOP,
        OP_INIT,
        OP_LBEG,
        OP_I_INC,
        OP_RD_I,
        OP_LATCH,
        OP_J_INC,
        OP_RD_J,
        OP_J_CMP,
        OP_I_WR,
        OP_L_END,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_LEFT_DONE,
        C_I_DONE,
        C_I_OUT,
        C_J_DONE,
        C_J_OUT,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic left_done;
        logic i_done;
        logic i_out;
        logic j_done;
        logic j_out;
        logic out_busy;
    } t_flags;

endpackage

>>> src/wlnr_ram.sv
// ----------------------------------------------------------------------------
// wlnr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wlnr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/wlnr_seq.sv
// ----------------------------------------------------------------------------
// wlnr_seq
// Microcode sequencer: a step counter walks a read-only program, each word
// issues one datapath operation and an optional conditional jump.
// ----------------------------------------------------------------------------
module wlnr_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wlnr_pkg::t_flags  i_flags,
    output wlnr_pkg::t_ctrl   o_ctrl
);

    localparam int PW = wlnr_pkg::PC_W;

    localparam logic [PW-1:0] S_IDLE  = PW'(0);
    localparam logic [PW-1:0] S_INIT  = PW'(1);
    localparam logic [PW-1:0] S_LCHK  = PW'(2);
    localparam logic [PW-1:0] S_LBEG  = PW'(3);
    localparam logic [PW-1:0] S_ICHK  = PW'(4);
    localparam logic [PW-1:0] S_IWIN  = PW'(5);
    localparam logic [PW-1:0] S_ISKIP = PW'(6);
    localparam logic [PW-1:0] S_IRD   = PW'(7);
    localparam logic [PW-1:0] S_ILAT  = PW'(8);
    localparam logic [PW-1:0] S_JCHK  = PW'(9);
    localparam logic [PW-1:0] S_JWIN  = PW'(10);
    localparam logic [PW-1:0] S_JSKIP = PW'(11);
    localparam logic [PW-1:0] S_JRD   = PW'(12);
    localparam logic [PW-1:0] S_JCMP  = PW'(13);
    localparam logic [PW-1:0] S_IWR   = PW'(14);
    localparam logic [PW-1:0] S_LEND  = PW'(15);
    localparam logic [PW-1:0] S_WAIT  = PW'(16);
    localparam logic [PW-1:0] S_EMIT  = PW'(17);

    function automatic wlnr_pkg::t_ctrl f_word(input logic [PW-1:0] pc);
        wlnr_pkg::t_ctrl w;
        case (pc)
            S_IDLE:  w = '{wlnr_pkg::OP_LOAD,  wlnr_pkg::C_NO_START,  S_IDLE};
            S_INIT:  w = '{wlnr_pkg::OP_INIT,  wlnr_pkg::C_NEVER,     S_IDLE};
            S_LCHK:  w = '{wlnr_pkg::OP_NOP,   wlnr_pkg::C_LEFT_DONE, S_WAIT};
            S_LBEG:  w = '{wlnr_pkg::OP_LBEG,  wlnr_pkg::C_NEVER,     S_IDLE};
            S_ICHK:  w = '{wlnr_pkg::OP_NOP,   wlnr_pkg::C_I_DONE,    S_LEND};
            S_IWIN:  w = '{wlnr_pkg::OP_NOP,   wlnr_pkg::C_I_OUT,     S_IRD};
            S_ISKIP: w = '{wlnr_pkg::OP_I_INC, wlnr_pkg::C_ALWAYS,    S_ICHK};
            S_IRD:   w = '{wlnr_pkg::OP_RD_I,  wlnr_pkg::C_NEVER,     S_IDLE};
            S_ILAT:  w = '{wlnr_pkg::OP_LATCH, wlnr_pkg::C_NEVER,     S_IDLE};
            S_JCHK:  w = '{wlnr_pkg::OP_NOP,   wlnr_pkg::C_J_DONE,    S_IWR};
            S_JWIN:  w = '{wlnr_pkg::OP_NOP,   wlnr_pkg::C_J_OUT,     S_JRD};
            S_JSKIP: w = '{wlnr_pkg::OP_J_INC, wlnr_pkg::C_ALWAYS,    S_JCHK};
            S_JRD:   w = '{wlnr_pkg::OP_RD_J,  wlnr_pkg::C_NEVER,     S_IDLE};
            S_JCMP:  w = '{wlnr_pkg::OP_J_CMP, wlnr_pkg::C_ALWAYS,    S_JCHK};
            S_IWR:   w = '{wlnr_pkg::OP_I_WR,  wlnr_pkg::C_ALWAYS,    S_ICHK};
            S_LEND:  w = '{wlnr_pkg::OP_L_END, wlnr_pkg::C_ALWAYS,    S_LCHK};
            S_WAIT:  w = '{wlnr_pkg::OP_NOP,   wlnr_pkg::C_OUT_BUSY,  S_WAIT};
            S_EMIT:  w = '{wlnr_pkg::OP_EMIT,  wlnr_pkg::C_ALWAYS,    S_IDLE};
            default: w = '{wlnr_pkg::OP_NOP,   wlnr_pkg::C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

    logic [PW-1:0]   r_pc;
    logic [PW-1:0]   n_pc;
    wlnr_pkg::t_ctrl w_ctrl;
    logic            w_take;

    always_comb begin
        w_ctrl = f_word(r_pc);
        case (w_ctrl.cond)
            wlnr_pkg::C_NEVER:     w_take = 1'b0;
            wlnr_pkg::C_ALWAYS:    w_take = 1'b1;
            wlnr_pkg::C_NO_START:  w_take = !i_flags.start;
            wlnr_pkg::C_LEFT_DONE: w_take = i_flags.left_done;
            wlnr_pkg::C_I_DONE:    w_take = i_flags.i_done;
            wlnr_pkg::C_I_OUT:     w_take = i_flags.i_out;
            wlnr_pkg::C_J_DONE:    w_take = i_flags.j_done;
            wlnr_pkg::C_J_OUT:     w_take = i_flags.j_out;
            wlnr_pkg::C_OUT_BUSY:  w_take = i_flags.out_busy;
            default:               w_take = 1'b0;
        endcase
        n_pc = w_take ? w_ctrl.target : r_pc + PW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_ctrl;

endmodule

>>> src/wlnr_dp.sv
// ----------------------------------------------------------------------------
// wlnr_dp
// Datapath: element and run-length memories, loop indexes, best-window
// tracking, the input load path and the result register.
// ----------------------------------------------------------------------------
module wlnr_dp #(
    parameter int MAX_ITEMS = wlnr_pkg::MAX_ITEMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wlnr_pkg::t_ctrl                 i_ctrl,
    output wlnr_pkg::t_flags                o_flags,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wlnr_pkg::VALUE_W-1:0]    s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wlnr_pkg::OTDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wlnr_pkg::WLEN_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = $clog2(MAX_ITEMS + 2);
    localparam int SW = ((IW > wlnr_pkg::WLEN_W) ? IW : wlnr_pkg::WLEN_W) + 1;
    localparam int VW = wlnr_pkg::VALUE_W;

    logic [CW-1:0]                  r_cnt;
    logic                           r_ovf;
    logic [wlnr_pkg::WLEN_W-1:0]    r_k;
    logic [IW-1:0]                  r_left;
    logic [IW-1:0]                  r_i;
    logic [IW-1:0]                  r_j;
    logic [CW-1:0]                  r_len;
    logic [CW-1:0]                  r_top;
    logic [CW-1:0]                  r_best;
    logic [IW-1:0]                  r_bwin;
    logic [VW-1:0]                  r_ei;
    logic                           r_ovalid;
    logic [wlnr_pkg::OTDATA_W-1:0]  r_odata;
    logic                           r_ouser;

    logic           w_load;
    logic           w_acc;
    logic           w_room;
    logic [IW-1:0]  w_i_m1;
    logic [IW-1:0]  w_j_m1;
    logic [AW-1:0]  w_e_raddr;
    logic [VW-1:0]  w_e_rdata;
    logic [CW-1:0]  w_rl_rdata;
    logic [SW-1:0]  w_k_x;
    logic [SW-1:0]  w_left_x;
    logic [SW-1:0]  w_win_end;
    logic [SW-1:0]  w_n_x;
    logic [SW-1:0]  w_i_x;
    logic [SW-1:0]  w_j_x;
    logic [CW:0]    w_cand;
    logic           w_better;
    logic [SW-1:0]  w_bl_x;
    logic [SW-1:0]  w_bw_x;
    logic [SW-1:0]  w_we_x;

    always_comb begin
        w_load    = (i_ctrl.op == wlnr_pkg::OP_LOAD);
        w_acc     = s_axis_tvalid && w_load;
        w_room    = (r_cnt != CW'(MAX_ITEMS));
        w_i_m1    = r_i - IW'(1);
        w_j_m1    = r_j - IW'(1);
        w_e_raddr = (i_ctrl.op == wlnr_pkg::OP_RD_I) ? w_i_m1[AW-1:0] : w_j_m1[AW-1:0];

        w_k_x     = SW'(r_k);
        w_left_x  = SW'(r_left);
        w_win_end = w_left_x + w_k_x;
        w_n_x     = SW'(r_cnt);
        w_i_x     = SW'(r_i);
        w_j_x     = SW'(r_j);

        o_flags.start     = s_axis_tvalid && s_axis_tlast;
        o_flags.left_done = (w_win_end > (w_n_x + SW'(1)));
        o_flags.i_done    = (w_i_x > w_n_x);
        o_flags.i_out     = !((w_i_x >= w_left_x) && (w_i_x < w_win_end));
        o_flags.j_done    = (r_j >= r_i);
        o_flags.j_out     = !((w_j_x >= w_left_x) && (w_j_x < w_win_end));
        o_flags.out_busy  = r_ovalid && !m_axis_tready;

        w_cand   = {1'b0, w_rl_rdata} + (CW + 1)'(1);
        w_better = ($signed(w_e_rdata) <= $signed(r_ei)) && (w_cand > {1'b0, r_len});

        w_bl_x = SW'(r_best) + w_k_x;
        w_bw_x = SW'(r_bwin);
        w_we_x = w_bw_x + w_k_x - SW'(1);
    end

    wlnr_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ITEMS)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_room),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (w_e_raddr),
        .o_rdata (w_e_rdata)
    );

    wlnr_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_ITEMS)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.op == wlnr_pkg::OP_I_WR),
        .i_waddr (w_i_m1[AW-1:0]),
        .i_wdata (r_len),
        .i_raddr (w_j_m1[AW-1:0]),
        .o_rdata (w_rl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_k      <= wlnr_pkg::WLEN_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_k <= i_cfg_data;
            end
            if (w_acc) begin
                if (w_room) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_ctrl.op == wlnr_pkg::OP_EMIT) begin
                r_cnt    <= '0;
                r_ovf    <= 1'b0;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            wlnr_pkg::OP_INIT: begin
                r_best <= '0;
                r_bwin <= '0;
                r_left <= IW'(1);
            end
            wlnr_pkg::OP_LBEG: begin
                r_top <= '0;
                r_i   <= IW'(1);
            end
            wlnr_pkg::OP_I_INC: begin
                r_i <= r_i + IW'(1);
            end
            wlnr_pkg::OP_RD_I: begin
                r_len <= CW'(1);
                r_j   <= IW'(1);
            end
            wlnr_pkg::OP_LATCH: begin
                r_ei <= w_e_rdata;
            end
            wlnr_pkg::OP_J_INC: begin
                r_j <= r_j + IW'(1);
            end
            wlnr_pkg::OP_J_CMP: begin
                if (w_better) begin
                    r_len <= w_cand[CW-1:0];
                end
                r_j <= r_j + IW'(1);
            end
            wlnr_pkg::OP_I_WR: begin
                if (r_len > r_top) begin
                    r_top <= r_len;
                end
                r_i <= r_i + IW'(1);
            end
            wlnr_pkg::OP_L_END: begin
                if (r_top > r_best) begin
                    r_best <= r_top;
                    r_bwin <= r_left;
                end
                r_left <= r_left + IW'(1);
            end
            wlnr_pkg::OP_EMIT: begin
                r_odata <= {w_we_x[wlnr_pkg::WEND_W-1:0],
                            w_bw_x[wlnr_pkg::WSTART_W-1:0],
                            w_bl_x[wlnr_pkg::BLEN_W-1:0]};
                r_ouser <= r_ovf;
                r_best  <= '0;
                r_bwin  <= '0;
            end
            default: begin
            end
        endcase
    end

    assign s_axis_tready = w_load;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign o_cfg_ready   = 1'b1;

endmodule

>>> src/windowed_longest_nondecreasing_run.sv
// ----------------------------------------------------------------------------
// windowed_longest_nondecreasing_run
// Elements arrive on the slave stream, one signed 32-bit value per item, one
// item per cycle while s_axis_tready is high; tlast marks the final element
// and starts the search. For every window of window_len positions the
// block runs a longest non-decreasing subsequence pass over the positions
// outside it and keeps the first window with the strictly greatest length.
// One result item follows on the master stream. While the search runs
// s_axis_tready is low. For each window the sequencer visits every position
// in turn; each position outside the window runs an inner loop that reads
// every earlier position outside the window from memory, one read at a
// time, and compares it. After the last window check the sequencer waits in
// S_WAIT until the output register is free, and S_EMIT then registers the
// result.
// A result that is not taken is held in the output register; loading of the
// next sequence goes on meanwhile, and the next search waits before emitting.
// Reset is synchronous: counters and flags clear and window_len returns to 1.
// The config channel is always ready and should only be written when idle.
// ----------------------------------------------------------------------------
module windowed_longest_nondecreasing_run #(
    parameter int MAX_ITEMS = wlnr_pkg::MAX_ITEMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // value
    input  logic [wlnr_pkg::VALUE_W-1:0]    s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // best_length, window_start, window_end
    output logic [wlnr_pkg::OTDATA_W-1:0]   m_axis_tdata,
    // overflow
    output logic                            m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wlnr_pkg::WLEN_W-1:0]     i_cfg_data
);

    wlnr_pkg::t_ctrl  w_ctrl;
    wlnr_pkg::t_flags w_flags;

    wlnr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    wlnr_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_flags       (w_flags),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

endmodule

>>> src/wlnr_checker.sv
// ----------------------------------------------------------------------------
// wlnr_checker
// Port-level checks of the search block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wlnr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [wlnr_pkg::OTDATA_W-1:0]   m_axis_tdata,
    input logic                            m_axis_tuser
);

    // The output register comes out of reset empty.
    `ASSERT_STD(a_out_empty_after_rst, $past(!i_rst_n) |-> !m_axis_tvalid)

    // A stalled result item holds its contents.
    `ASSERT_STD(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

    // The final element of a sequence closes the input until the search ends.
    `ASSERT_STD(a_last_closes_input,
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)

    // A result item only appears at the end of a search.
    `ASSERT_STD(a_result_after_search, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

endmodule

bind windowed_longest_nondecreasing_run wlnr_checker u_wlnr_checker (.*);
